// ----- hdl/rqts_pkg.sv -----
`default_nettype none

package rqts_pkg;

	localparam int TASK_W      = 6;
	localparam int TASK_DEPTH  = 64;
	localparam int LEVELS      = 8;
	localparam int LEVEL_W     = 3;
	localparam int ROT_W       = 5;
	localparam int AFF_W       = 2;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 8;

	localparam int NUM_TASKS_DEF = 64;

	typedef enum logic [1:0] {
		OP_SELECT     = 2'd0,
		OP_WRITE_TASK = 2'd1,
		OP_WRITE_HEAD = 2'd2,
		OP_UNUSED     = 2'd3
	} op_t;

	typedef struct packed {
		logic [TASK_W-1:0] next;
		logic              running;
		logic [AFF_W-1:0]  affinity;
	} task_entry_t;

	// First level to look at for each value of the rotation index.
	localparam logic [LEVEL_W-1:0] WEIGHT_TABLE [32] = '{
		3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd2,
		3'd0, 3'd0, 3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd4,
		3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd6,
		3'd0, 3'd1, 3'd0, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0
	};

endpackage

`default_nettype wire

// ----- hdl/ready_queue_task_selector.sv -----
`default_nettype none

// Channel  Dir  tdata                                   tuser
// s_*      in   task_req, next_task, task_running,      op
//               task_affinity, queue, head_valid,
//               head_task, cpu, current_task
// m_*      out  chosen_task                             found
//
// A select examines the queue levels in turn and visits the list links of a
// level one by one (with one extra step when the head is the current task),
// limited by the single read port of the task memory.
// Reset clears the head valid bits, the rotation index and the output; the
// task memory is not cleared. A stalled result holds in the output register
// while further write transactions are taken.

module ready_queue_task_selector #(
	parameter int NUM_TASKS = rqts_pkg::NUM_TASKS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// task_req[5:0], next_task[11:6], task_running[12], task_affinity[14:13],
	// queue[17:15], head_valid[18], head_task[24:19], cpu[26:25],
	// current_task[32:27], zero fill above
	input  wire logic [rqts_pkg::IN_DATA_W-1:0]      s_tdata,
	// op[1:0]
	input  wire logic [1:0]                          s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// chosen_task[5:0], zero fill above
	output logic [rqts_pkg::OUT_DATA_W-1:0]          m_tdata,
	// found[0]
	output logic                                     m_tuser
);

	localparam int STEP_W = $clog2(NUM_TASKS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_LINK,
		ST_STEP,
		ST_DONE
	} state_t;

	state_t state_q;

	rqts_pkg::op_t                       op;
	logic [rqts_pkg::TASK_W-1:0]         task_req;
	rqts_pkg::task_entry_t               wr_entry;
	logic [rqts_pkg::LEVEL_W-1:0]        queue;
	logic                                head_valid;
	logic [rqts_pkg::TASK_W-1:0]         head_task;
	logic [rqts_pkg::AFF_W-1:0]          cpu;
	logic [rqts_pkg::TASK_W-1:0]         current_task;

	assign op                = rqts_pkg::op_t'(s_tuser);
	assign task_req          = s_tdata[5:0];
	assign wr_entry.next     = s_tdata[11:6];
	assign wr_entry.running  = s_tdata[12];
	assign wr_entry.affinity = s_tdata[14:13];
	assign queue             = s_tdata[17:15];
	assign head_valid        = s_tdata[18];
	assign head_task         = s_tdata[24:19];
	assign cpu               = s_tdata[26:25];
	assign current_task      = s_tdata[32:27];

	rqts_pkg::task_entry_t task_mem [rqts_pkg::TASK_DEPTH];
	rqts_pkg::task_entry_t rdata_s1;
	logic [rqts_pkg::TASK_W-1:0] rd_addr;

	logic [rqts_pkg::LEVELS-1:0]  head_vld_q;
	logic [rqts_pkg::TASK_W-1:0]  head_task_q [rqts_pkg::LEVELS];

	logic [rqts_pkg::ROT_W-1:0]   rot_q;
	logic [rqts_pkg::ROT_W-1:0]   rot_next;
	logic [rqts_pkg::LEVEL_W-1:0] lv_q;
	logic [rqts_pkg::LEVEL_W-1:0] n_q;
	logic [rqts_pkg::AFF_W-1:0]   cpu_q;
	logic [rqts_pkg::TASK_W-1:0]  cur_q;
	logic [rqts_pkg::TASK_W-1:0]  h_q;
	logic [rqts_pkg::TASK_W-1:0]  q_q;
	logic [STEP_W-1:0]            steps_q;
	logic [STEP_W-1:0]            steps_inc;
	logic [rqts_pkg::TASK_W-1:0]  res_q;
	logic                         found_q;

	logic accept;
	logic wr_task;
	logic wr_head;
	logic head_ok;
	logic eligible;
	logic walk_end;
	logic last_level;
	logic pick;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign wr_task  = accept && (op == rqts_pkg::OP_WRITE_TASK);
	assign wr_head  = accept && (op == rqts_pkg::OP_WRITE_HEAD);

	assign rot_next   = rot_q + 1'b1;
	assign head_ok    = head_vld_q[lv_q] && (32'(head_task_q[lv_q]) < NUM_TASKS);
	assign eligible   = !rdata_s1.running && (rdata_s1.affinity == cpu_q);
	assign steps_inc  = steps_q + 1'b1;
	assign walk_end   = (rdata_s1.next == h_q) || (steps_inc == STEP_W'(NUM_TASKS));
	assign last_level = (n_q == rqts_pkg::LEVEL_W'(rqts_pkg::LEVELS - 1));
	assign pick       = (state_q == ST_STEP) && eligible;

	// The next link is taken straight from the read data so that the walk
	// visits one task per cycle.
	always_comb begin
		unique case (state_q)
			ST_LEVEL:        rd_addr = head_task_q[lv_q];
			ST_LINK, ST_STEP: rd_addr = rdata_s1.next;
			default:         rd_addr = q_q;
		endcase
	end

	// Writes happen only while idle, so a walk never reads an entry that is
	// being written in the same cycle.
	always_ff @(posedge clk) begin
		if (wr_task) begin
			task_mem[task_req] <= wr_entry;
		end
		rdata_s1 <= task_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_head) begin
			head_task_q[queue] <= head_task;
		end else if (pick) begin
			head_task_q[lv_q] <= q_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_vld_q <= '0;
			rot_q      <= '0;
			lv_q       <= '0;
			n_q        <= '0;
			cpu_q      <= '0;
			cur_q      <= '0;
			h_q        <= '0;
			q_q        <= '0;
			steps_q    <= '0;
			res_q      <= '0;
			found_q    <= 1'b0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= 1'b0;
		end else begin
			if (m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (op)
							rqts_pkg::OP_WRITE_HEAD: begin
								head_vld_q[queue] <= head_valid;
							end
							rqts_pkg::OP_SELECT: begin
								rot_q   <= rot_next;
								lv_q    <= rqts_pkg::WEIGHT_TABLE[rot_next];
								n_q     <= '0;
								cpu_q   <= cpu;
								cur_q   <= current_task;
								state_q <= ST_LEVEL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LEVEL: begin
					if (head_ok) begin
						h_q     <= head_task_q[lv_q];
						q_q     <= head_task_q[lv_q];
						steps_q <= '0;
						if (head_task_q[lv_q] == cur_q) begin
							state_q <= ST_LINK;
						end else begin
							state_q <= ST_STEP;
						end
					end else if (last_level) begin
						res_q   <= cur_q;
						found_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						lv_q <= lv_q + 1'b1;
						n_q  <= n_q + 1'b1;
					end
				end
				ST_LINK: begin
					q_q     <= rdata_s1.next;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (eligible) begin
						res_q   <= q_q;
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (walk_end) begin
						if (last_level) begin
							res_q   <= cur_q;
							found_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							lv_q    <= lv_q + 1'b1;
							n_q     <= n_q + 1'b1;
							state_q <= ST_LEVEL;
						end
					end else begin
						q_q     <= rdata_s1.next;
						steps_q <= steps_inc;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= rqts_pkg::OUT_DATA_W'(res_q);
						m_tuser  <= found_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rqts_checker.sv -----
`default_nettype none

module rqts_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [rqts_pkg::IN_DATA_W-1:0] s_tdata,
	input wire logic [1:0]                     s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [rqts_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic                           m_tuser
);

	logic s_accept;

	assign s_accept = s_tvalid && s_tready;

	// A result that is not taken holds until it is.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The chosen task is six bits wide; the fill above it stays zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:6] == 2'b00))
		else $error("result fill bits set");

	// A transaction that is not a select never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_tuser != rqts_pkg::OP_SELECT) && !m_tvalid |=> !m_tvalid)
		else $error("result after a write transaction");

	// A select occupies the block, so the next cycle takes no transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_tuser == rqts_pkg::OP_SELECT) |=> !s_tready)
		else $error("input ready during a select");

endmodule

bind ready_queue_task_selector rqts_checker u_rqts_checker (.*);

`default_nettype wire

// ----- dv/ready_queue_task_selector_tb.sv -----
`default_nettype none

module ready_queue_task_selector_tb;

	localparam int NUM_TASKS    = rqts_pkg::NUM_TASKS_DEF;
	localparam int ITEM_TARGET  = 650;
	localparam int DRAIN_CYCLES = 8 * (NUM_TASKS + 2) + 20;
	localparam int STALL_LIMIT  = 6000;

	// Mirror of the selector: task table, queue heads and rotation index, plus the
	// picks still owed by the block in the order the selects were taken.
	class pick_scoreboard;
		typedef struct {
			logic [rqts_pkg::TASK_W-1:0] chosen;
			logic                        found;
		} pick_t;

		logic [rqts_pkg::TASK_W-1:0] link [rqts_pkg::TASK_DEPTH];
		logic                        busy [rqts_pkg::TASK_DEPTH];
		logic [rqts_pkg::AFF_W-1:0]  aff [rqts_pkg::TASK_DEPTH];
		logic                        head_live [rqts_pkg::LEVELS];
		logic [rqts_pkg::TASK_W-1:0] head_id [rqts_pkg::LEVELS];
		logic [rqts_pkg::ROT_W-1:0]  rot;
		pick_t                       pending_picks [$];
		int errors, selects, hits, task_writes, head_writes, ignored;

		function new();
			foreach (link[i]) begin
				link[i] = '0;
				busy[i] = 1'b0;
				aff[i]  = '0;
			end
			foreach (head_live[i]) begin
				head_live[i] = 1'b0;
				head_id[i]   = '0;
			end
			rot = '0;
			errors = 0;
			selects = 0;
			hits = 0;
			task_writes = 0;
			head_writes = 0;
			ignored = 0;
		endfunction

		function void note_input(rqts_pkg::op_t op, logic [rqts_pkg::IN_DATA_W-1:0] d);
			logic [rqts_pkg::TASK_W-1:0]  h, q, cur;
			logic [rqts_pkg::LEVEL_W-1:0] lv;
			logic [rqts_pkg::AFF_W-1:0]   cpu;
			int n, steps;
			bit hit, stop;
			pick_t p;
			case (op)
				rqts_pkg::OP_WRITE_TASK: begin
					link[d[5:0]] = d[11:6];
					busy[d[5:0]] = d[12];
					aff[d[5:0]]  = d[14:13];
					task_writes++;
				end
				rqts_pkg::OP_WRITE_HEAD: begin
					head_live[d[17:15]] = d[18];
					head_id[d[17:15]]   = d[24:19];
					head_writes++;
				end
				rqts_pkg::OP_SELECT: begin
					cpu = d[26:25];
					cur = d[32:27];
					rot = rot + 1'b1;
					lv = rqts_pkg::WEIGHT_TABLE[rot];
					hit = 1'b0;
					p.chosen = cur;
					p.found  = 1'b0;
					for (n = 0; n < rqts_pkg::LEVELS && !hit; n++) begin
						// Heads are six bits wide, so with 64 tasks none is out of range.
						if (head_live[lv] && int'(head_id[lv]) < NUM_TASKS) begin
							h = head_id[lv];
							// A head that is the caller's own task is passed over at first.
							q = (h != cur) ? h : link[h];
							steps = 0;
							stop = 1'b0;
							while (!hit && !stop) begin
								if (!busy[q] && aff[q] == cpu) begin
									hit = 1'b1;
									head_id[lv] = q;
									p.chosen = q;
									p.found = 1'b1;
								end else begin
									q = link[q];
									steps++;
									stop = (q == h) || (steps >= NUM_TASKS);
								end
							end
						end
						lv = lv + 1'b1;
					end
					pending_picks.push_back(p);
					selects++;
					if (hit)
						hits++;
				end
				default: ignored++;
			endcase
		endfunction

		function void check_result(logic [rqts_pkg::TASK_W-1:0] chosen, logic found);
			pick_t p;
			if (pending_picks.size() == 0) begin
				$error("result with no select pending: chosen_task %0d found %0d", chosen, found);
				errors++;
			end else begin
				p = pending_picks.pop_front();
				if (chosen !== p.chosen) begin
					$error("chosen_task: expected %0d, actual %0d", p.chosen, chosen);
					errors++;
				end
				if (found !== p.found) begin
					$error("found: expected %0d, actual %0d", p.found, found);
					errors++;
				end
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [rqts_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [1:0]                      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rqts_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tuser;

	pick_scoreboard sb;
	int  sent;
	int  burst_left;
	int  idle_cycles = 0;
	int  stall_left = 0;
	int  stall_mode = 0;
	bit  paused;

	ready_queue_task_selector #(
		.NUM_TASKS(NUM_TASKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver alternates between segments of steady readiness, random
	// readiness and hard stalls.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(1, 40);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= 1'b0;
			default: m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && s_tvalid && s_tready)
			sb.note_input(rqts_pkg::op_t'(s_tuser), s_tdata);
		if (arst_n === 1'b1 && m_tvalid && m_tready)
			sb.check_result(m_tdata[rqts_pkg::TASK_W-1:0], m_tuser);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Random filler for the fields that an operation does not use.
	function automatic logic [rqts_pkg::IN_DATA_W-1:0] noise();
		logic [rqts_pkg::IN_DATA_W-1:0] w;
		w = '0;
		w[31:0] = $urandom();
		w[32] = $urandom_range(0, 1);
		return w;
	endfunction

	function automatic logic [rqts_pkg::IN_DATA_W-1:0] task_word(int t, int nxt, int run,
		int af);
		logic [rqts_pkg::IN_DATA_W-1:0] w;
		w = noise();
		w[5:0] = t[5:0];
		w[11:6] = nxt[5:0];
		w[12] = run[0];
		w[14:13] = af[1:0];
		return w;
	endfunction

	function automatic logic [rqts_pkg::IN_DATA_W-1:0] head_word(int lv, int live, int t);
		logic [rqts_pkg::IN_DATA_W-1:0] w;
		w = noise();
		w[17:15] = lv[2:0];
		w[18] = live[0];
		w[24:19] = t[5:0];
		return w;
	endfunction

	function automatic logic [rqts_pkg::IN_DATA_W-1:0] select_word(int cpu, int cur);
		logic [rqts_pkg::IN_DATA_W-1:0] w;
		w = noise();
		w[26:25] = cpu[1:0];
		w[32:27] = cur[5:0];
		return w;
	endfunction

	// Holds the transaction until it is taken, then, when the current burst runs
	// out, may insert a gap. Valid is only lowered inside a gap.
	task automatic push(rqts_pkg::op_t op, logic [rqts_pkg::IN_DATA_W-1:0] d);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op != rqts_pkg::OP_UNUSED)
			sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic random_item();
		int r, k, t0, lv, j;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			lv = $urandom_range(0, rqts_pkg::LEVELS - 1);
			push(rqts_pkg::OP_SELECT, select_word($urandom_range(0, 3),
				($urandom_range(0, 9) < 3) ? int'(sb.head_id[lv]) : $urandom_range(0, 63)));
		end else if (r < 68) begin
			push(rqts_pkg::OP_WRITE_TASK, task_word($urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 9) < 3, $urandom_range(0, 3)));
		end else if (r < 88) begin
			push(rqts_pkg::OP_WRITE_HEAD, head_word($urandom_range(0, 7),
				$urandom_range(0, 3) != 0, $urandom_range(0, 63)));
		end else if (r < 96) begin
			// Rebuild one level as a proper ring of consecutive tasks.
			k = $urandom_range(2, 6);
			t0 = $urandom_range(0, 63);
			for (j = 0; j < k; j++)
				push(rqts_pkg::OP_WRITE_TASK, task_word((t0 + j) % 64,
					(t0 + (j + 1) % k) % 64, $urandom_range(0, 9) < 3,
					$urandom_range(0, 3)));
			push(rqts_pkg::OP_WRITE_HEAD, head_word($urandom_range(0, 7), 1, t0));
		end else begin
			push(rqts_pkg::OP_UNUSED, noise());
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		paused = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= rqts_pkg::OP_SELECT;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 24);

		// Directed part. Only tasks 0 to 5 and 63 are reachable from a head here,
		// and every link among them stays inside that set.
		push(rqts_pkg::OP_SELECT, select_word(3, 63));
		push(rqts_pkg::OP_UNUSED, noise());
		push(rqts_pkg::OP_WRITE_TASK, task_word(0, 1, 0, 0));
		push(rqts_pkg::OP_WRITE_TASK, task_word(1, 2, 1, 1));
		push(rqts_pkg::OP_WRITE_TASK, task_word(2, 0, 0, 2));
		// Tasks 4 and 5 loop on each other, so a walk from 3 never returns to it.
		push(rqts_pkg::OP_WRITE_TASK, task_word(3, 4, 1, 1));
		push(rqts_pkg::OP_WRITE_TASK, task_word(4, 5, 1, 1));
		push(rqts_pkg::OP_WRITE_TASK, task_word(5, 4, 1, 1));
		push(rqts_pkg::OP_WRITE_TASK, task_word(63, 63, 0, 3));
		push(rqts_pkg::OP_WRITE_HEAD, head_word(0, 1, 0));
		push(rqts_pkg::OP_WRITE_HEAD, head_word(3, 1, 3));
		push(rqts_pkg::OP_SELECT, select_word(0, 5));
		push(rqts_pkg::OP_SELECT, select_word(0, 0));
		push(rqts_pkg::OP_SELECT, select_word(2, 0));
		push(rqts_pkg::OP_SELECT, select_word(1, 9));
		push(rqts_pkg::OP_WRITE_HEAD, head_word(7, 1, 63));
		push(rqts_pkg::OP_SELECT, select_word(3, 63));
		push(rqts_pkg::OP_WRITE_HEAD, head_word(7, 0, 63));
		push(rqts_pkg::OP_SELECT, select_word(3, 63));
		push(rqts_pkg::OP_WRITE_HEAD, head_word(0, 0, 0));
		push(rqts_pkg::OP_SELECT, select_word(1, 3));
		push(rqts_pkg::OP_WRITE_TASK, task_word(63, 63, 1, 3));
		push(rqts_pkg::OP_SELECT, select_word(3, 2));

		// Give every task an entry before any random select can walk to it.
		for (int i = 0; i < rqts_pkg::TASK_DEPTH; i++)
			push(rqts_pkg::OP_WRITE_TASK, task_word(i, $urandom_range(0, 63),
				$urandom_range(0, 9) < 3, $urandom_range(0, 3)));

		while (sent < ITEM_TARGET) begin
			if (!paused && sent >= ITEM_TARGET / 2) begin
				// Let the block drain completely once in mid-run.
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending_picks.size() != 0)
					@(posedge clk);
				paused = 1'b1;
			end
			random_item();
		end
		s_tvalid <= 1'b0;

		while (sb.pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d selects (%0d picked from a queue, %0d fell back to the caller)",
			sb.selects, sb.hits, sb.selects - sb.hits);
		$display("and %0d task-entry writes, %0d head writes, %0d ignored transactions",
			sb.task_writes, sb.head_writes, sb.ignored);
		if (sb.errors == 0 && sb.pending_picks.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
